### hdl/lmsdfe_pkg.sv
// Shared types and constants of the LMS decision-feedback equaliser.
// Used by the cell, the arithmetic unit and the top level; depends on nothing.
`default_nettype none
package lmsdfe_pkg;
   localparam int SAMPLE_W = 16;
   localparam int TAP_W    = 24;
   localparam int ERR_W    = 17;
   localparam int SUM_W    = 41;
   localparam int UPD_W    = 35;
   localparam int MU_W     = 16;
   localparam int PROD_W   = UPD_W + MU_W + 1;
   localparam logic signed [TAP_W-1:0]    TAP_ONE  = 24'sh100000;
   localparam logic signed [SAMPLE_W-1:0] ONE_Q13  = 16'sd8192;
   localparam logic [1:0]                 DEC_POS  = 2'b01;
   localparam logic [1:0]                 DEC_NEG  = 2'b11;
   localparam logic                       REG_FF   = 1'b0;
   localparam logic                       REG_FB   = 1'b1;

   // One tap of the filter with the line entry that it multiplies.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x_re;
      logic signed [SAMPLE_W-1:0] x_im;
      logic signed [TAP_W-1:0]    t_re;
      logic signed [TAP_W-1:0]    t_im;
      logic                       fb;
      logic                       live;
   } cell_type;

   typedef struct packed {
      logic rotate;
      logic line_shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic run;
      logic upd;
      logic clr;
   } alu_ctrl_type;
endpackage
`default_nettype wire

### hdl/lms_decision_feedback_equalizer_core.sv
// LMS decision-feedback equaliser, complex QPSK, ring of tap cells.
// The result is registered after the filter pass, once any earlier result has been taken.
// A new sample is taken only in idle, after two passes
// of the tap ring through the one shared multiply unit (filter, then update);
// a result left waiting holds the core in rounding.
// Reset clears the lines and taps (centre feedforward tap 1.0), step sizes 328.
`default_nettype none
module lms_decision_feedback_equalizer_core import lmsdfe_pkg::*; #(
   parameter int FF_TAPS = 8,
   parameter int FB_TAPS = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_re,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_im,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_equalized_re,
   output logic signed [SAMPLE_W-1:0]      rsp_equalized_im,
   output logic signed [1:0]               rsp_decision_re,
   output logic signed [1:0]               rsp_decision_im,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [2:0]                 csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   localparam int NCELL    = FF_TAPS + FB_TAPS;
   localparam int LOOP_LEN = NCELL + 3;
   localparam int CNT_W    = $clog2(LOOP_LEN);
   localparam int ACC_W    = SUM_W + 2 + $clog2(NCELL + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_ROUND, ST_UPD, ST_DEC} state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [MU_W-1:0]         mu_ff_ff, mu_fb_ff;
   logic signed [ERR_W-1:0] err_re_ff, err_im_ff;
   logic                    dpos_re_ff, dpos_im_ff;
   logic                    rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] y_re_ff, y_im_ff;
   logic signed [1:0]       d_re_ff, d_im_ff;

   cell_type                cells [NCELL];
   cell_type                tail;
   alu_ctrl_type            alu_ctrl;
   logic signed [ACC_W-1:0] acc_re, acc_im;
   logic                    accept, ring_run, last;

   logic signed [ACC_W-1:0]    r_re, r_im;
   logic signed [SAMPLE_W-1:0] y_re_in, y_im_in;
   logic                       pos_re_in, pos_im_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign ring_run  = (state_ff == ST_ACC) || (state_ff == ST_UPD);
   assign last      = (cnt_ff == CNT_W'(LOOP_LEN - 1));

   always_comb begin
      alu_ctrl.run = ring_run;
      alu_ctrl.upd = (state_ff == ST_UPD);
      alu_ctrl.clr = accept;
   end

   // The ring of tap cells; the head leaves through the arithmetic unit.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      cell_ctrl_type           cctl;
      cell_type                rin;
      logic signed [SAMPLE_W-1:0] lre, lim;
      always_comb begin
         cctl.rotate     = ring_run;
         cctl.line_shift = (k < FF_TAPS) ? accept : (state_ff == ST_DEC);
         rin = (k == NCELL - 1) ? tail : cells[(k + 1) % NCELL];
         if (k == 0) begin
            lre = req_sample_re;
            lim = req_sample_im;
         end else if (k == FF_TAPS) begin
            lre = dpos_re_ff ? ONE_Q13 : -ONE_Q13;
            lim = dpos_im_ff ? ONE_Q13 : -ONE_Q13;
         end else begin
            lre = cells[(k + NCELL - 1) % NCELL].x_re;
            lim = cells[(k + NCELL - 1) % NCELL].x_im;
         end
      end
      lmsdfe_cell #(
         .IS_FB     (k >= FF_TAPS),
         .IS_CENTER (k == FF_TAPS / 2)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cctl),
         .rot_in   (rin),
         .line_re  (lre),
         .line_im  (lim),
         .cell_out (cells[k])
      );
   end

   lmsdfe_alu #(.ACC_W(ACC_W)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .head   (cells[0]),
      .err_re (err_re_ff),
      .err_im (err_im_ff),
      .mu_ff  (mu_ff_ff),
      .mu_fb  (mu_fb_ff),
      .tail   (tail),
      .acc_re (acc_re),
      .acc_im (acc_im)
   );

   // Round the filter sum to Q2.13 and saturate; slice the signs.
   always_comb begin
      r_re = (acc_re + ACC_W'(64'sd1 <<< 19)) >>> 20;
      r_im = (acc_im + ACC_W'(64'sd1 <<< 19)) >>> 20;
      if (r_re > ACC_W'(32767))       y_re_in = 16'sd32767;
      else if (r_re < ACC_W'(-32768)) y_re_in = -16'sd32768;
      else                            y_re_in = r_re[SAMPLE_W-1:0];
      if (r_im > ACC_W'(32767))       y_im_in = 16'sd32767;
      else if (r_im < ACC_W'(-32768)) y_im_in = -16'sd32768;
      else                            y_im_in = r_im[SAMPLE_W-1:0];
      pos_re_in = (y_re_in > 16'sd0);
      pos_im_in = (y_im_in > 16'sd0);
   end

   // Sequencer, result register and step-size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mu_ff_ff     <= 16'd328;
         mu_fb_ff     <= 16'd328;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_paddr[2])
               REG_FF:  mu_ff_ff <= csr_pwdata[MU_W-1:0];
               REG_FB:  mu_fb_ff <= csr_pwdata[MU_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) state_ff <= ST_ACC;
            end
            ST_ACC, ST_UPD: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last) begin
                  cnt_ff   <= '0;
                  state_ff <= (state_ff == ST_ACC) ? ST_ROUND : ST_DEC;
               end
            end
            ST_ROUND: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  y_re_ff      <= y_re_in;
                  y_im_ff      <= y_im_in;
                  d_re_ff      <= pos_re_in ? DEC_POS : DEC_NEG;
                  d_im_ff      <= pos_im_in ? DEC_POS : DEC_NEG;
                  dpos_re_ff   <= pos_re_in;
                  dpos_im_ff   <= pos_im_in;
                  err_re_ff    <= (pos_re_in ? 17'sd8192 : -17'sd8192) - ERR_W'(y_re_in);
                  err_im_ff    <= (pos_im_in ? 17'sd8192 : -17'sd8192) - ERR_W'(y_im_in);
                  state_ff     <= ST_UPD;
               end
            end
            ST_DEC:  state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_equalized_re = y_re_ff;
   assign rsp_equalized_im = y_im_ff;
   assign rsp_decision_re  = d_re_ff;
   assign rsp_decision_im  = d_im_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = {16'd0, (csr_paddr[2] == REG_FB) ? mu_fb_ff : mu_ff_ff};
endmodule
`default_nettype wire

### hdl/lmsdfe_cell.sv
// One cell of the tap ring: holds a line entry and its complex tap.
// Depends on lmsdfe_pkg.
`default_nettype none
module lmsdfe_cell import lmsdfe_pkg::*; #(
   parameter bit IS_FB     = 1'b0,
   parameter bit IS_CENTER = 1'b0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cell_ctrl_type              ctrl,
   input  wire cell_type                   rot_in,
   input  wire logic signed [SAMPLE_W-1:0] line_re,
   input  wire logic signed [SAMPLE_W-1:0] line_im,
   output cell_type                        cell_out
);
   cell_type cell_ff;

   // Rotation moves the whole cell on; a line shift moves only the entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.x_re <= '0;
         cell_ff.x_im <= '0;
         cell_ff.t_re <= IS_CENTER ? TAP_ONE : '0;
         cell_ff.t_im <= '0;
         cell_ff.fb   <= IS_FB;
         cell_ff.live <= 1'b1;
      end else if (ctrl.rotate) begin
         cell_ff <= rot_in;
      end else if (ctrl.line_shift) begin
         cell_ff.x_re <= line_re;
         cell_ff.x_im <= line_im;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

### hdl/lmsdfe_alu.sv
// Shared complex multiply unit: filter accumulation and tap update, three stages.
// Depends on lmsdfe_pkg.
`default_nettype none
module lmsdfe_alu import lmsdfe_pkg::*; #(
   parameter int ACC_W = 46
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire alu_ctrl_type             ctrl,
   input  wire cell_type                 head,
   input  wire logic signed [ERR_W-1:0]  err_re,
   input  wire logic signed [ERR_W-1:0]  err_im,
   input  wire logic [MU_W-1:0]          mu_ff,
   input  wire logic [MU_W-1:0]          mu_fb,
   output cell_type                      tail,
   output logic signed [ACC_W-1:0]       acc_re,
   output logic signed [ACC_W-1:0]       acc_im
);
   cell_type s1_ff, s2_ff, s3_ff;
   logic signed [SUM_W-1:0]  sum_re_ff, sum_im_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;

   logic signed [TAP_W-1:0]  a1, a2;
   logic signed [SUM_W-2:0]  p0, p1, p2, p3;
   logic signed [SUM_W-1:0]  sum_re_in, sum_im_in, im_raw;
   logic signed [MU_W:0]     mu;
   logic signed [PROD_W-1:0] prod_re_in, prod_im_in;
   logic signed [ACC_W-1:0]  add_re, add_im;
   logic signed [PROD_W-1:0] rnd_re, rnd_im;
   logic signed [TAP_W+7:0]  new_re, new_im;
   cell_type                 s3_in;

   // Stage one: the same four products serve both passes.
   always_comb begin
      a1 = ctrl.upd ? TAP_W'(err_re) : head.t_re;
      a2 = ctrl.upd ? TAP_W'(err_im) : head.t_im;
      p0 = (SUM_W-1)'(head.x_re) * (SUM_W-1)'(a1);
      p1 = (SUM_W-1)'(head.x_im) * (SUM_W-1)'(a2);
      p2 = (SUM_W-1)'(head.x_re) * (SUM_W-1)'(a2);
      p3 = (SUM_W-1)'(head.x_im) * (SUM_W-1)'(a1);
      sum_re_in = SUM_W'(p0) + SUM_W'(p1);
      im_raw    = SUM_W'(p2) - SUM_W'(p3);
      sum_im_in = ctrl.upd ? -im_raw : im_raw;
   end

   // Stage two: step-size product, or accumulation of the filter sum.
   always_comb begin
      mu = {1'b0, (s1_ff.fb ? mu_fb : mu_ff)};
      prod_re_in = PROD_W'($signed(sum_re_ff[UPD_W-1:0])) * PROD_W'(mu);
      prod_im_in = PROD_W'($signed(sum_im_ff[UPD_W-1:0])) * PROD_W'(mu);
      add_re = s1_ff.fb ? -ACC_W'(sum_re_ff) : ACC_W'(sum_re_ff);
      add_im = s1_ff.fb ? -ACC_W'(sum_im_ff) : ACC_W'(sum_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.live <= 1'b0;
         s2_ff.live <= 1'b0;
         s3_ff.live <= 1'b0;
         acc_re_ff  <= '0;
         acc_im_ff  <= '0;
      end else begin
         if (ctrl.clr) begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end else if (ctrl.run && !ctrl.upd && s1_ff.live) begin
            acc_re_ff <= acc_re_ff + add_re;
            acc_im_ff <= acc_im_ff + add_im;
         end
         if (ctrl.run) begin
            s1_ff <= head;
            s2_ff <= s1_ff;
            s3_ff <= s3_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.run) begin
         sum_re_ff  <= sum_re_in;
         sum_im_ff  <= sum_im_in;
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

   // Stage three: round, add or subtract and saturate the tap that sits in
   // stage two alongside its product, then register it back towards the ring.
   always_comb begin
      rnd_re = (prod_re_ff + PROD_W'(64'sd1 <<< 21)) >>> 22;
      rnd_im = (prod_im_ff + PROD_W'(64'sd1 <<< 21)) >>> 22;
      if (s2_ff.fb) begin
         new_re = (TAP_W+8)'(s2_ff.t_re) - (TAP_W+8)'(rnd_re);
         new_im = (TAP_W+8)'(s2_ff.t_im) - (TAP_W+8)'(rnd_im);
      end else begin
         new_re = (TAP_W+8)'(s2_ff.t_re) + (TAP_W+8)'(rnd_re);
         new_im = (TAP_W+8)'(s2_ff.t_im) + (TAP_W+8)'(rnd_im);
      end
      s3_in = s2_ff;
      if (ctrl.upd && s2_ff.live) begin
         if (new_re > (TAP_W+8)'(32'sd8388607))       s3_in.t_re = 24'sd8388607;
         else if (new_re < (TAP_W+8)'(-32'sd8388608)) s3_in.t_re = -24'sd8388608;
         else                                          s3_in.t_re = new_re[TAP_W-1:0];
         if (new_im > (TAP_W+8)'(32'sd8388607))       s3_in.t_im = 24'sd8388607;
         else if (new_im < (TAP_W+8)'(-32'sd8388608)) s3_in.t_im = -24'sd8388608;
         else                                          s3_in.t_im = new_im[TAP_W-1:0];
      end
   end

   assign tail   = s3_ff;
   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench of the LMS decision-feedback equaliser core.
// A built-in predictor follows every accepted sample; depends on lmsdfe_pkg and the core.
`default_nettype none
module tb import lmsdfe_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_FF     = 8;
   localparam int NUM_FB     = 4;
   localparam int LATENCY    = NUM_FF + NUM_FB + 4;
   localparam int CYCLE_STOP = 600000;
   localparam logic [2:0] ADDR_FF = {REG_FF, 2'b00};
   localparam logic [2:0] ADDR_FB = {REG_FB, 2'b00};
   localparam longint TAP_HI = 64'sd8388607;
   localparam longint TAP_LO = -64'sd8388608;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] eq_re;
      logic signed [SAMPLE_W-1:0] eq_im;
      logic [1:0]                 dec_re;
      logic [1:0]                 dec_im;
   } symbol_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] s_re;
      logic signed [SAMPLE_W-1:0] s_im;
   } sample_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_re;
   logic signed [SAMPLE_W-1:0] req_sample_im;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_equalized_re;
   logic signed [SAMPLE_W-1:0] rsp_equalized_im;
   logic signed [1:0]          rsp_decision_re;
   logic signed [1:0]          rsp_decision_im;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [2:0]                 csr_paddr;
   logic [31:0]                csr_pwdata;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   // Predictor state.
   longint  line_re [NUM_FF];
   longint  line_im [NUM_FF];
   longint  dline_re [NUM_FB];
   longint  dline_im [NUM_FB];
   longint  fwd_re [NUM_FF];
   longint  fwd_im [NUM_FF];
   longint  bwd_re [NUM_FB];
   longint  bwd_im [NUM_FB];
   int      smp_ptr;
   int      dec_ptr;
   longint  mu_fwd;
   longint  mu_bwd;

   sample_type pending_samples[$];
   symbol_type expected_symbols[$];
   int      mismatches;
   int      symbols_checked;
   int      cycles;
   int      send_gap;
   int      recv_stall;
   bit      send_burst;
   bit      recv_burst;

   lms_decision_feedback_equalizer_core #(.FF_TAPS(NUM_FF), .FB_TAPS(NUM_FB)) i_dut (.*);

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint round_q(input longint v, input int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Filter, slice and adapt for one sample; returns the equalised symbol.
   function automatic symbol_type equalize(input sample_type s);
      symbol_type r;
      longint  acc_re, acc_im, yr, yi, er, ei, xr, xi, pr, pi;
      int      k, dr, di;
      acc_re = 0;
      acc_im = 0;
      line_re[smp_ptr] = s.s_re;
      line_im[smp_ptr] = s.s_im;
      for (int i = 0; i < NUM_FF; i++) begin
         k = (i + smp_ptr) % NUM_FF;
         acc_re += line_re[k] * fwd_re[i] + line_im[k] * fwd_im[i];
         acc_im += line_re[k] * fwd_im[i] - line_im[k] * fwd_re[i];
      end
      for (int i = 0; i < NUM_FB; i++) begin
         k = (i + dec_ptr) % NUM_FB;
         xr = dline_re[k] * 8192;
         xi = dline_im[k] * 8192;
         acc_re -= xr * bwd_re[i] + xi * bwd_im[i];
         acc_im -= xr * bwd_im[i] - xi * bwd_re[i];
      end
      yr = clip(round_q(acc_re, 20), -32768, 32767);
      yi = clip(round_q(acc_im, 20), -32768, 32767);
      // A zero part slices to minus one.
      dr = yr > 0 ? 1 : -1;
      di = yi > 0 ? 1 : -1;
      er = dr * 8192 - yr;
      ei = di * 8192 - yi;
      for (int i = 0; i < NUM_FF; i++) begin
         k = (i + smp_ptr) % NUM_FF;
         pr = er * line_re[k] + ei * line_im[k];
         pi = er * line_im[k] - ei * line_re[k];
         fwd_re[i] = clip(fwd_re[i] + round_q(mu_fwd * pr, 22), TAP_LO, TAP_HI);
         fwd_im[i] = clip(fwd_im[i] + round_q(mu_fwd * pi, 22), TAP_LO, TAP_HI);
      end
      for (int i = 0; i < NUM_FB; i++) begin
         k = (i + dec_ptr) % NUM_FB;
         xr = dline_re[k] * 8192;
         xi = dline_im[k] * 8192;
         pr = er * xr + ei * xi;
         pi = er * xi - ei * xr;
         bwd_re[i] = clip(bwd_re[i] - round_q(mu_bwd * pr, 22), TAP_LO, TAP_HI);
         bwd_im[i] = clip(bwd_im[i] - round_q(mu_bwd * pi, 22), TAP_LO, TAP_HI);
      end
      dec_ptr = (dec_ptr + NUM_FB - 1) % NUM_FB;
      smp_ptr = (smp_ptr + NUM_FF - 1) % NUM_FF;
      dline_re[dec_ptr] = dr;
      dline_im[dec_ptr] = di;
      r.eq_re  = yr[15:0];
      r.eq_im  = yi[15:0];
      r.dec_re = dr > 0 ? DEC_POS : DEC_NEG;
      r.dec_im = di > 0 ? DEC_POS : DEC_NEG;
      return r;
   endfunction

   function automatic int draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, 3);
   endfunction

   // Driver: presents queued samples and predicts each accepted transaction.
   always @(posedge clock) begin
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_symbols.push_back(equalize({req_sample_re, req_sample_im}));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               nxt = pending_samples.pop_front();
               req_valid     <= 1'b1;
               req_sample_re <= nxt.s_re;
               req_sample_im <= nxt.s_im;
               if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
               send_gap <= draw_wait(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      symbol_type got, want;
      int      s;
      if (reset) begin
         rsp_ready  <= 1'b1;
         recv_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         got = {rsp_equalized_re, rsp_equalized_im, rsp_decision_re, rsp_decision_im};
         if (expected_symbols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result transaction %p", got);
         end else begin
            want = expected_symbols.pop_front();
            symbols_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: symbol %0d expected eq=(%0d,%0d) dec=(%0d,%0d)",
                            " got eq=(%0d,%0d) dec=(%0d,%0d)"},
                           symbols_checked, want.eq_re, want.eq_im,
                           $signed(want.dec_re), $signed(want.dec_im), got.eq_re, got.eq_im,
                           $signed(got.dec_re), $signed(got.dec_im));
            end
         end
         if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
         s = draw_wait(recv_burst);
         recv_stall <= s;
         rsp_ready  <= (s == 0);
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready  <= (recv_stall == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_STOP) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Register write then read-back, only while the core is idle.
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_FF) mu_fwd = data[15:0];
      else                 mu_bwd = data[15:0];
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[15:0] !== data[15:0]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: register at %0d read %h, expected %h", addr, csr_prdata[15:0],
                     data[15:0]);
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_samples.size() == 0 && !req_valid && expected_symbols.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // Mostly noisy QPSK symbols, some full-range noise.
   task automatic queue_random(input int count, input int amp);
      sample_type s;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 8) begin
            s.s_re = 16'(($urandom_range(0, 1) ? amp : -amp)
                         + $signed($urandom_range(0, 3000)) - 1500);
            s.s_im = 16'(($urandom_range(0, 1) ? amp : -amp)
                         + $signed($urandom_range(0, 3000)) - 1500);
         end else begin
            s = $urandom;
         end
         pending_samples.push_back(s);
      end
   endtask

   // Stimulus.
   initial begin
      req_valid = 1'b0; req_sample_re = '0; req_sample_im = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      mismatches = 0; symbols_checked = 0; cycles = 0;
      send_burst = 0; recv_burst = 0;
      for (int i = 0; i < NUM_FF; i++) begin
         line_re[i] = 0; line_im[i] = 0; fwd_re[i] = 0; fwd_im[i] = 0;
      end
      for (int i = 0; i < NUM_FB; i++) begin
         dline_re[i] = 0; dline_im[i] = 0; bwd_re[i] = 0; bwd_im[i] = 0;
      end
      fwd_re[NUM_FF/2] = 64'sd1 <<< 20;
      smp_ptr = 0; dec_ptr = 0;
      mu_fwd = 328; mu_bwd = 328;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero samples (zero output slices negative), extremes, early feedback.
      for (int n = 0; n < 3; n++) pending_samples.push_back('0);
      pending_samples.push_back({16'sh7fff, 16'sh7fff});
      pending_samples.push_back({16'sh8000, 16'sh8000});
      pending_samples.push_back({16'sh7fff, 16'sh8000});
      pending_samples.push_back({16'sh8000, 16'sh7fff});
      pending_samples.push_back({16'sd1, -16'sd1});
      pending_samples.push_back({-16'sd1, 16'sd1});
      pending_samples.push_back({16'sd8192, 16'sd8192});
      pending_samples.push_back({-16'sd8192, 16'sd8192});
      pending_samples.push_back({16'sd8192, -16'sd8192});
      pending_samples.push_back({-16'sd8192, -16'sd8192});
      for (int n = 0; n < 8; n++) pending_samples.push_back({16'sh7fff, 16'sh7fff});
      drain();

      // Random phases over several step-size settings, extremes included.
      queue_random(250, 8192);
      drain();
      write_csr(ADDR_FF, 32'h0000_0000);
      write_csr(ADDR_FB, 32'h0000_0000);
      queue_random(200, 6000);
      drain();
      write_csr(ADDR_FF, 32'($urandom) | 32'h0000_ffff);
      write_csr(ADDR_FB, 32'($urandom) | 32'h0000_ffff);
      queue_random(200, 8192);
      drain();
      write_csr(ADDR_FF, {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4000))});
      write_csr(ADDR_FB, {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4000))});
      queue_random(300, 7000);
      drain();
      write_csr(ADDR_FF, 32'($urandom));
      write_csr(ADDR_FB, 32'($urandom));
      queue_random(250, 9000);
      drain();

      $display("Covered %0d symbols over five step-size settings, reset, zero and full scale,",
               symbols_checked);
      $display("with random gaps on the sample side and random stalls on the result side.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
